// ----- src/tvm_pkg.sv -----
// shared types, register codes and the sine table for the tone mixer
package tvm_pkg;

	localparam int TVM_VOICES = 3;
	localparam int TVM_SINE_ENTRIES = 360;

	// register indexes on the configuration port
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_VOLUME = 2'd1;
	localparam logic [1:0] REG_SILENCE = 2'd2;

	// dac volume codes, all others pass the average unchanged
	localparam logic [2:0] VOL_HALF = 3'd1;
	localparam logic [2:0] VOL_X2 = 3'd3;
	localparam logic [2:0] VOL_X4 = 3'd4;
	localparam logic [2:0] VOL_X8 = 3'd5;
	localparam logic [2:0] VOL_RESET = 3'd2;

	localparam logic [23:0] PHASE_MULT = 24'd180;
	// floor(2^28 / 360), quotient is exact or one short
	localparam int RECIP_SHIFT = 28;
	localparam logic [19:0] RECIP_360 = 20'd745654;

	typedef struct packed {
		logic       start;
		logic       dac_mode;
		logic       silence;
		logic [2:0] dac_volume;
	} tvm_cmd_t;

	localparam logic [7:0] SINE_ROM [TVM_SINE_ENTRIES] = '{
		8'd64, 8'd66, 8'd68, 8'd70, 8'd72, 8'd75, 8'd77, 8'd79,
		8'd81, 8'd83, 8'd85, 8'd87, 8'd90, 8'd92, 8'd94, 8'd95,
		8'd97, 8'd99, 8'd101, 8'd103, 8'd105, 8'd106, 8'd108, 8'd110,
		8'd111, 8'd113, 8'd114, 8'd115, 8'd117, 8'd118, 8'd119, 8'd120,
		8'd121, 8'd122, 8'd123, 8'd124, 8'd124, 8'd125, 8'd126, 8'd126,
		8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd128, 8'd127, 8'd127,
		8'd127, 8'd127, 8'd127, 8'd126, 8'd126, 8'd125, 8'd124, 8'd124,
		8'd123, 8'd122, 8'd121, 8'd120, 8'd119, 8'd118, 8'd117, 8'd115,
		8'd114, 8'd113, 8'd111, 8'd110, 8'd108, 8'd106, 8'd105, 8'd103,
		8'd101, 8'd99, 8'd97, 8'd95, 8'd94, 8'd92, 8'd90, 8'd87,
		8'd85, 8'd83, 8'd81, 8'd79, 8'd77, 8'd75, 8'd72, 8'd70,
		8'd68, 8'd66, 8'd64, 8'd61, 8'd59, 8'd57, 8'd55, 8'd52,
		8'd50, 8'd48, 8'd46, 8'd44, 8'd42, 8'd40, 8'd37, 8'd35,
		8'd33, 8'd32, 8'd30, 8'd28, 8'd26, 8'd24, 8'd22, 8'd21,
		8'd19, 8'd17, 8'd16, 8'd14, 8'd13, 8'd12, 8'd10, 8'd9,
		8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd3, 8'd2,
		8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd2,
		8'd3, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9,
		8'd10, 8'd12, 8'd13, 8'd14, 8'd16, 8'd17, 8'd19, 8'd21,
		8'd22, 8'd24, 8'd26, 8'd28, 8'd30, 8'd31, 8'd33, 8'd35,
		8'd37, 8'd40, 8'd42, 8'd44, 8'd46, 8'd48, 8'd50, 8'd52,
		8'd55, 8'd57, 8'd59, 8'd61, 8'd63, 8'd66, 8'd68, 8'd70,
		8'd72, 8'd75, 8'd77, 8'd79, 8'd81, 8'd83, 8'd85, 8'd87,
		8'd90, 8'd92, 8'd94, 8'd96, 8'd97, 8'd99, 8'd101, 8'd103,
		8'd105, 8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd115,
		8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd124,
		8'd124, 8'd125, 8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd127,
		8'd127, 8'd128, 8'd127, 8'd127, 8'd127, 8'd127, 8'd127, 8'd126,
		8'd126, 8'd125, 8'd124, 8'd124, 8'd123, 8'd122, 8'd121, 8'd120,
		8'd119, 8'd118, 8'd117, 8'd115, 8'd114, 8'd113, 8'd111, 8'd110,
		8'd108, 8'd106, 8'd105, 8'd103, 8'd101, 8'd99, 8'd97, 8'd95,
		8'd94, 8'd92, 8'd90, 8'd87, 8'd85, 8'd83, 8'd81, 8'd79,
		8'd77, 8'd75, 8'd72, 8'd70, 8'd68, 8'd66, 8'd64, 8'd61,
		8'd59, 8'd57, 8'd55, 8'd52, 8'd50, 8'd48, 8'd46, 8'd44,
		8'd42, 8'd40, 8'd37, 8'd35, 8'd33, 8'd32, 8'd30, 8'd28,
		8'd26, 8'd24, 8'd22, 8'd21, 8'd19, 8'd17, 8'd16, 8'd14,
		8'd13, 8'd12, 8'd10, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5,
		8'd4, 8'd3, 8'd3, 8'd2, 8'd1, 8'd1, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd1, 8'd1, 8'd2, 8'd3, 8'd3, 8'd4, 8'd5,
		8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd12, 8'd13, 8'd14,
		8'd16, 8'd17, 8'd19, 8'd21, 8'd22, 8'd24, 8'd26, 8'd28,
		8'd30, 8'd32, 8'd33, 8'd35, 8'd37, 8'd40, 8'd42, 8'd44,
		8'd46, 8'd48, 8'd50, 8'd52, 8'd55, 8'd57, 8'd59, 8'd61
	};

endpackage

// ----- src/tvm_core.sv -----
// voice sequencer with one shared multiplier, square counters and sine rom
module tvm_core
	import tvm_pkg::*;
#(
	parameter int VOICES = TVM_VOICES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tvm_cmd_t            cmd,
	input  logic [VOICES*16-1:0] half_period,
	input  logic [VOICES*16-1:0] freq,
	input  logic [VOICES*4-1:0]  vol,
	output logic                busy,
	output logic [7:0]          next_level
);

	localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

	typedef enum logic [3:0] {
		C_IDLE,
		C_DIG,
		C_FREQ,
		C_PROD,
		C_QUOT,
		C_REM,
		C_ROM,
		C_ACC,
		C_SCALE
	} state_t;

	state_t      state_q;
	logic [VW-1:0] v_q;
	logic [2:0]  vol_code_q;
	logic [31:0] idx_q;
	logic [15:0] tick_q [VOICES];
	logic        flag_q [VOICES];
	logic        any_q;
	logic [7:0]  avg_q;
	logic [7:0]  next_level_q;
	logic [55:0] mul_q;
	logic [18:0] phase_q;
	logic [7:0]  rom_q;

	// item payload, held for the whole sequence
	logic [15:0] hp_q [VOICES];
	logic [15:0] fq_q [VOICES];
	logic [3:0]  vol_q [VOICES];

	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic [15:0] hp_eff;
	logic        wrap;
	logic        flag_new;
	logic        voice_on;
	logic [18:0] rem_raw;
	logic [8:0]  rem_fix;
	logic [7:0]  sample;
	logic [8:0]  avg_sum;
	logic [7:0]  avg_next;

	function automatic logic [7:0] scale_level(input logic [7:0] a, input logic [2:0] code);
		logic [7:0] s;
		case (code)
			VOL_HALF: s = {1'b0, a[7:1]};
			VOL_X2:   s = a[7] ? 8'hFF : {a[6:0], 1'b0};
			VOL_X4:   s = (a[7:6] != 2'b00) ? 8'hFF : {a[5:0], 2'b00};
			VOL_X8:   s = (a[7:5] != 3'b000) ? 8'hFF : {a[4:0], 3'b000};
			default:  s = a;
		endcase
		return s;
	endfunction

	assign voice_on = (vol_q[v_q] != 4'd0);

	// square voice step
	assign hp_eff = (hp_q[v_q] == 16'd0) ? 16'd1 : hp_q[v_q];
	assign wrap = (tick_q[v_q] >= (hp_eff - 16'd1));
	assign flag_new = flag_q[v_q] ^ wrap;

	// shared multiplier operands
	always_comb begin
		case (state_q)
			C_FREQ: begin
				mul_a = {16'd0, fq_q[v_q]};
				mul_b = PHASE_MULT;
			end
			C_PROD: begin
				mul_a = idx_q;
				mul_b = mul_q[23:0];
			end
			C_QUOT: begin
				mul_a = {13'd0, mul_q[31:13]};
				mul_b = {4'd0, RECIP_360};
			end
			C_REM: begin
				mul_a = {21'd0, mul_q[RECIP_SHIFT+10:RECIP_SHIFT]};
				mul_b = 24'(TVM_SINE_ENTRIES);
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 24'd0;
			end
		endcase
	end

	// remainder is below twice the table length, one correction
	assign rem_raw = phase_q - mul_q[18:0];
	assign rem_fix = (rem_raw >= 19'(TVM_SINE_ENTRIES)) ?
		9'(rem_raw - 19'(TVM_SINE_ENTRIES)) : rem_raw[8:0];

	assign sample = voice_on ? rom_q : 8'd0;
	assign avg_sum = {1'b0, avg_q} + {1'b0, sample};
	assign avg_next = (v_q == '0) ? sample : avg_sum[8:1];

	always_ff @(posedge clk) begin
		if (cmd.start && state_q == C_IDLE) begin
			for (int v = 0; v < VOICES; v++) begin
				hp_q[v] <= half_period[v*16 +: 16];
				fq_q[v] <= freq[v*16 +: 16];
				vol_q[v] <= vol[v*4 +: 4];
			end
		end
		// full-width product, the quotient step needs bits above 32
		mul_q <= {24'd0, mul_a} * mul_b;
		if (state_q == C_QUOT)
			phase_q <= mul_q[31:13];
		if (state_q == C_ROM)
			rom_q <= SINE_ROM[rem_fix];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			v_q <= '0;
			vol_code_q <= VOL_RESET;
			idx_q <= 32'd0;
			any_q <= 1'b0;
			avg_q <= 8'd0;
			next_level_q <= 8'd0;
			for (int v = 0; v < VOICES; v++) begin
				tick_q[v] <= 16'd0;
				flag_q[v] <= 1'b0;
			end
		end else begin
			case (state_q)
				C_IDLE: begin
					if (cmd.start) begin
						v_q <= '0;
						any_q <= 1'b0;
						vol_code_q <= cmd.dac_volume;
						if (cmd.dac_mode)
							idx_q <= idx_q + 32'd1;
						if (cmd.silence)
							next_level_q <= 8'd0;
						else if (cmd.dac_mode)
							state_q <= C_FREQ;
						else
							state_q <= C_DIG;
					end
				end
				C_DIG: begin
					flag_q[v_q] <= flag_new;
					tick_q[v_q] <= wrap ? 16'd1 : tick_q[v_q] + 16'd1;
					if (v_q == LAST_VOICE) begin
						next_level_q <= {7'd0, any_q | (flag_new & voice_on)};
						state_q <= C_IDLE;
					end else begin
						any_q <= any_q | (flag_new & voice_on);
						v_q <= v_q + VW'(1);
					end
				end
				C_FREQ:  state_q <= C_PROD;
				C_PROD:  state_q <= C_QUOT;
				C_QUOT:  state_q <= C_REM;
				C_REM:   state_q <= C_ROM;
				C_ROM:   state_q <= C_ACC;
				C_ACC: begin
					avg_q <= avg_next;
					if (v_q == LAST_VOICE) begin
						state_q <= C_SCALE;
					end else begin
						v_q <= v_q + VW'(1);
						state_q <= C_FREQ;
					end
				end
				C_SCALE: begin
					next_level_q <= scale_level(avg_q, vol_code_q);
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign busy = (state_q != C_IDLE);
	assign next_level = next_level_q;

endmodule

// ----- src/three_voice_tone_mixer.sv -----
// three-voice tone mixer: stream ports, register file and output register
// One input beat per sample tick carries every voice's half-period, frequency
// and volume; each accepted beat gives exactly one output beat.
// The output beat carries the level worked out on the previous tick, plus a
// flag in m_tuser that is set when it differs from the level driven before.
// The output beat is loaded in the accept cycle, so it is valid in the cycle
// after the input beat is taken.
// After the accept the next level is computed by a sequencer over the voices,
// during which s_tready is low, so a new beat is taken only once the sequencer
// is back in idle. Square mode runs one counter step per voice. Sine mode runs
// six steps per voice through one shared multiplier (phase step, phase,
// reciprocal quotient, remainder, rom read, average) plus one scaling step.
// With silence set a beat can be taken each cycle while m_tready is high.
// A waiting output beat that is not yet taken holds s_tready low, so a
// receiver stall throttles the input side and nothing is lost.
// Reset clears the counters, the sample index and both levels; the volume
// register resets to pass-through. Registers are written over the apb port.
module three_voice_tone_mixer
	import tvm_pkg::*;
#(
	parameter int VOICES = TVM_VOICES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// half_period per voice, then freq per voice, then vol per voice
	input  logic [((VOICES*36+7)/8)*8-1:0]   s_tdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// level
	output logic [7:0]                       m_tdata,
	// level_changed
	output logic [0:0]                       m_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [3:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic       mode_q;
	logic [2:0] volume_q;
	logic       silence_q;
	logic       m_tvalid_q;
	logic [7:0] level_q;
	logic       changed_q;
	logic [7:0] driven_level_q;
	logic       accept;
	logic       busy;
	logic [7:0] next_level;
	tvm_cmd_t   cmd;

	assign pready = 1'b1;
	assign s_tready = !busy && (!m_tvalid_q || m_tready);
	assign accept = s_tvalid && s_tready;

	assign cmd.start = accept;
	assign cmd.dac_mode = mode_q;
	assign cmd.silence = silence_q;
	assign cmd.dac_volume = volume_q;

	tvm_core #(
		.VOICES(VOICES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.half_period(s_tdata[VOICES*16-1:0]),
		.freq(s_tdata[VOICES*32-1:VOICES*16]),
		.vol(s_tdata[VOICES*36-1:VOICES*32]),
		.busy(busy),
		.next_level(next_level)
	);

	always_comb begin
		case (paddr[3:2])
			REG_MODE:    prdata = {31'd0, mode_q};
			REG_VOLUME:  prdata = {29'd0, volume_q};
			REG_SILENCE: prdata = {31'd0, silence_q};
			default:     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			volume_q <= VOL_RESET;
			silence_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_MODE:    mode_q <= pwdata[0];
				REG_VOLUME:  volume_q <= pwdata[2:0];
				REG_SILENCE: silence_q <= pwdata[0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			driven_level_q <= 8'd0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
			driven_level_q <= next_level;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_q <= next_level;
			changed_q <= (next_level != driven_level_q);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = level_q;
	assign m_tuser = changed_q;

`ifndef SYNTHESIS
	// no beat is taken while the sequencer is still working
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !busy)
		else $error("input taken while sequencer busy");

	// every accepted beat shows up at the output in the next cycle
	a_out_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_tvalid && m_tdata == driven_level_q))
		else $error("output beat missing after accept");

	// changed flag compares against the level driven before
	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_tuser[0] == (m_tdata != $past(driven_level_q))))
		else $error("level_changed does not match level history");
`endif

endmodule
